// File: hw/rtl/deq_pkg.sv
// deq_pkg: types, sizes and helpers shared by the double-ended queue.
// No dependencies; compiled first.

package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int OPC_W   = 3;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_PEEK       = 3'd4
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// what a cell takes on the next clock
	typedef enum logic [1:0] {
		CM_HOLD,
		CM_TAKE_LEFT,
		CM_TAKE_RIGHT,
		CM_LOAD
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
	} cell_ctrl_t;

	typedef logic [DATA_WIDTH-1:0] word_t;

	// keep the low DATA_WIDTH bits of a pushed value (sign-extend if wider)
	function automatic word_t to_word(input logic [WORD_W-1:0] v);
		return DATA_WIDTH'(signed'(v));
	endfunction

	// sign-extend a stored word to the port width
	function automatic logic [WORD_W-1:0] from_word(input word_t w);
		return WORD_W'(signed'(w));
	endfunction

endpackage

// File: hw/rtl/deq_if.sv
// deq_if: valid/ready channels for queue commands and results.
// Depends on deq_pkg for field widths.

interface deq_cmd_if import deq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OPC_W-1:0]          opcode;
	logic signed [WORD_W-1:0]  data_in;

	modport source (output valid, output opcode, output data_in, input ready);
	modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STAT_W-1:0]         status;
	logic signed [WORD_W-1:0]  front_value;
	logic signed [WORD_W-1:0]  back_value;
	logic [COUNT_W-1:0]        entry_count;

	modport source (output valid, output status, output front_value, output back_value,
		output entry_count, input ready);
	modport sink   (input valid, input status, input front_value, input back_value,
		input entry_count, output ready);
endinterface

// File: hw/rtl/deq_cell.sv
// deq_cell: one storage slot of the queue row; takes its own word, a neighbor's
// word or new data each clock. Depends on deq_pkg.

module deq_cell import deq_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  word_t      left,
	input  word_t      right,
	input  word_t      load_data,
	output word_t      q,
	output word_t      nxt
);

	word_t data_q;

	always_comb begin
		case (ctrl.mode)
			CM_TAKE_LEFT:  nxt = left;
			CM_TAKE_RIGHT: nxt = right;
			CM_LOAD:       nxt = load_data;
			default:       nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign q = data_q;

endmodule

// File: hw/rtl/double_ended_queue_top.sv
// double_ended_queue_top: bounded deque built as a row of shifting cells.
// Depends on deq_pkg, deq_if and deq_cell.
//
// Usage:
//   cmd carries one operation per transfer (opcode, data_in): push back,
//   push front, pop back, pop front, peek; unused opcodes act as peek.
//   rsp returns exactly one result per command: status, front and back
//   values after the operation (-1 when empty) and the entry count.
//   The result is registered: a command taken at a clock edge shows on rsp
//   after that edge. Throughput is one command per cycle while rsp.ready is
//   high; cells update at once as the front always sits in cell 0 and
//   the back in cell count-1; each operation is at most one shift or load.
//   The result register frees cmd.ready whenever it is empty or being
//   drained, so a stalled receiver holds off only new commands.
//   Push on full gives overflow, pop on empty gives underflow; both leave
//   the contents unchanged. Reset clears the count and the result valid;
//   cell contents are not cleared and only live entries are ever shown.

module double_ended_queue_top import deq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	deq_cmd_if.sink    cmd,
	deq_rsp_if.source  rsp
);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               rsp_valid_q;
	status_t            status_q;
	logic [WORD_W-1:0]  front_q;
	logic [WORD_W-1:0]  back_q;
	logic [COUNT_W-1:0] entry_count_q;

	cell_ctrl_t         ctrl [DEPTH];
	word_t              cell_q [DEPTH];
	word_t              cell_nxt [DEPTH];
	word_t              push_word;
	status_t            status_d;
	logic               accept;
	logic               full;
	logic               empty;
	logic [IDX_W-1:0]   back_idx;
	logic [WORD_W-1:0]  front_d;
	logic [WORD_W-1:0]  back_d;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign push_word = to_word(cmd.data_in);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		for (int i = 0; i < DEPTH; i++) begin
			ctrl[i].mode = CM_HOLD;
		end
		case (opcode_t'(cmd.opcode))
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = ST_OVERFLOW;
				end else if (accept) begin
					count_d = count_q + 1'b1;
					for (int i = 0; i < DEPTH; i++) begin
						if (count_q == CNT_W'(i)) ctrl[i].mode = CM_LOAD;
					end
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_OVERFLOW;
				end else if (accept) begin
					count_d = count_q + 1'b1;
					for (int i = 0; i < DEPTH; i++) begin
						ctrl[i].mode = CM_TAKE_LEFT;
					end
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = ST_UNDERFLOW;
				end else if (accept) begin
					count_d = count_q - 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_UNDERFLOW;
				end else if (accept) begin
					count_d = count_q - 1'b1;
					for (int i = 0; i < DEPTH; i++) begin
						ctrl[i].mode = CM_TAKE_RIGHT;
					end
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// cell 0 takes new data from the left, the last cell keeps its own word when the row shifts toward the front
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (g == 0) begin : g_first
			assign left_w = push_word;
		end else begin : g_mid_l
			assign left_w = cell_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w = cell_q[g];
		end else begin : g_mid_r
			assign right_w = cell_q[g+1];
		end
		deq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl[g]),
			.left      (left_w),
			.right     (right_w),
			.load_data (push_word),
			.q         (cell_q[g]),
			.nxt       (cell_nxt[g])
		);
	end

	assign back_idx = IDX_W'(count_d - 1'b1);

	always_comb begin
		if (count_d == '0) begin
			front_d = '1;
			back_d  = '1;
		end else begin
			front_d = from_word(cell_nxt[0]);
			back_d  = from_word(cell_nxt[back_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			front_q       <= front_d;
			back_q        <= back_d;
			entry_count_q <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.front_value = front_q;
	assign rsp.back_value  = back_q;
	assign rsp.entry_count = entry_count_q;

endmodule
